### hdl/tvfs_pkg.sv
// tvfs_pkg: shared constants, register indexes and multiply-accumulate control types
// for the trilinear vector field sampler. No dependencies.
`default_nettype none

package tvfs_pkg;

  // Grid geometry
  localparam int DIM_X = 16;
  localparam int DIM_Y = 16;
  localparam int DIM_Z = 16;
  localparam int NUM_GRIDS = 4;
  localparam int NUM_CORNERS = 8;
  localparam int GRID_CELLS = DIM_X * DIM_Y * DIM_Z;
  localparam int STRIDE_Y = DIM_X;
  localparam int STRIDE_Z = DIM_X * DIM_Y;
  localparam int DIM_MAX = (DIM_X > DIM_Y) ? ((DIM_X > DIM_Z) ? DIM_X : DIM_Z)
                                           : ((DIM_Y > DIM_Z) ? DIM_Y : DIM_Z);
  localparam int LIN_W = $clog2(GRID_CELLS);
  localparam int AXIS_IDX_W = $clog2(DIM_MAX);
  localparam int SEL_W = 2;
  localparam int MEM_AW = LIN_W + SEL_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  // Field widths
  localparam int WIDX_W = 12;
  localparam int VAL_W = 16;
  localparam int WORD_W = 3 * VAL_W;
  localparam int COORD_W = 32;
  localparam int OUT_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int FRAC_W = 26;      // fraction, Q.16, saturated to +/-256.0
  localparam int FRAC_LO_W = 13;   // fraction split for the two multiply passes
  localparam int LERP_W = 40;      // intermediate Q.8 values
  localparam int MUL_A_W = 38;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W = 64;
  localparam int G_W = ACC_W - 16; // grid coordinate magnitude, Q.16

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Z = 3'd5;

  localparam logic [CFG_DATA_W-1:0] INV_SPACING_RESET = 32'h0001_0000;

  // Multiply-accumulate control
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD
  } mac_op_t;

  typedef enum logic [1:0] {
    MAC_SH0,
    MAC_SH13,
    MAC_SH16
  } mac_shift_t;

  typedef struct packed {
    mac_op_t    op;
    mac_shift_t shift;
  } mac_ctl_t;

endpackage

`default_nettype wire

### hdl/trilinear_vector_field_sampler.sv
// trilinear_vector_field_sampler: four grids of 3-component Q8.8 vectors, trilinear sample.
// Write requests are accepted back to back; a sample request keeps busy high until its
// result is ready, and the result shows on done as busy falls, so samples never overlap.
// Timing is set by the single shared multiplier and the single-port store: three axis passes,
// the eight corner reads, then 21 lerps, each of operand prep, two multiply passes, write-back.
// rst (synchronous) returns registers to 0 / 1.0 spacing and idles; the store is not cleared.
// Depends on tvfs_pkg and tvfs_mac.
`default_nettype none

module trilinear_vector_field_sampler (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 command,
  input  wire logic        [tvfs_pkg::SEL_W-1:0]    array_select,
  input  wire logic        [tvfs_pkg::WIDX_W-1:0]   write_index,
  input  wire logic signed [tvfs_pkg::VAL_W-1:0]    value_x,
  input  wire logic signed [tvfs_pkg::VAL_W-1:0]    value_y,
  input  wire logic signed [tvfs_pkg::VAL_W-1:0]    value_z,
  input  wire logic signed [tvfs_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [tvfs_pkg::COORD_W-1:0]  coord_y,
  input  wire logic signed [tvfs_pkg::COORD_W-1:0]  coord_z,
  // result channel: one-cycle strobe, no back-pressure
  output logic                                      done,
  output logic signed      [tvfs_pkg::OUT_W-1:0]    sample_x,
  output logic signed      [tvfs_pkg::OUT_W-1:0]    sample_y,
  output logic signed      [tvfs_pkg::OUT_W-1:0]    sample_z,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic        [tvfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [tvfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = tvfs_pkg::AXIS_IDX_W;
  localparam int LW = tvfs_pkg::LIN_W;
  localparam int FW = tvfs_pkg::FRAC_W;
  localparam int GW = tvfs_pkg::G_W;
  localparam int VW = tvfs_pkg::LERP_W;
  localparam logic [2:0] LAST_STEP = 3'd6;
  localparam logic [1:0] LAST_AXIS = 2'd2;
  localparam logic [1:0] LAST_COMP = 2'd2;
  localparam logic [3:0] LAST_READ = 4'd8;

  localparam logic [AW-1:0] DIM_X_M1 = AW'(tvfs_pkg::DIM_X - 1);
  localparam logic [AW-1:0] DIM_Y_M1 = AW'(tvfs_pkg::DIM_Y - 1);
  localparam logic [AW-1:0] DIM_Z_M1 = AW'(tvfs_pkg::DIM_Z - 1);

  // +/-256.0 grid units in Q.16
  localparam logic [FW-1:0] FRAC_POS = FW'(32'd16777216);
  localparam logic [FW-1:0] FRAC_NEG = FW'(-32'sd16777216);
  localparam logic [GW-1:0] FRAC_POS_G = GW'(32'd16777216);

  localparam logic signed [47:0] OUT_MAX = 48'sd8388607;
  localparam logic signed [47:0] OUT_MIN = -48'sd8388608;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AX_D,   // coordinate minus origin, magnitude and sign
    S_AX_M0,  // magnitude times low half of reciprocal spacing
    S_AX_M1,  // plus high half
    S_AX_F,   // base corners and fraction
    S_OFS,    // per-axis linear offsets
    S_RD,     // corner reads
    S_LP,     // lerp operand prep
    S_L0,     // lerp multiply, low fraction bits
    S_L1,     // lerp multiply, high fraction bits
    S_LW      // lerp write-back
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [tvfs_pkg::COORD_W-1:0] origin [3];
  logic [tvfs_pkg::CFG_DATA_W-1:0] inv_spacing [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      inv_spacing[0] <= tvfs_pkg::INV_SPACING_RESET;
      inv_spacing[1] <= tvfs_pkg::INV_SPACING_RESET;
      inv_spacing[2] <= tvfs_pkg::INV_SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tvfs_pkg::REG_ORIGIN_X:      origin[0] <= cfg_data;
        tvfs_pkg::REG_ORIGIN_Y:      origin[1] <= cfg_data;
        tvfs_pkg::REG_ORIGIN_Z:      origin[2] <= cfg_data;
        tvfs_pkg::REG_INV_SPACING_X: inv_spacing[0] <= cfg_data;
        tvfs_pkg::REG_INV_SPACING_Y: inv_spacing[1] <= cfg_data;
        tvfs_pkg::REG_INV_SPACING_Z: inv_spacing[2] <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Grid store: {grid, linear index}, word = {z, y, x} components.
  // Single port: writes in idle, corner reads during a sample.
  // ---------------------------------------------------------------------------
  logic [tvfs_pkg::WORD_W-1:0] mem [tvfs_pkg::MEM_DEPTH];
  logic [tvfs_pkg::WORD_W-1:0] mem_rdata;
  logic [tvfs_pkg::MEM_AW-1:0] mem_addr;
  logic mem_we;

  logic accept;
  logic [31:0] widx_ext;
  logic [LW-1:0] rd_lin;

  logic [1:0] sel;
  logic [3:0] rd_cnt;
  logic [LW-1:0] ofs [3][2];

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign widx_ext = {{(32 - tvfs_pkg::WIDX_W){1'b0}}, write_index};
  assign mem_we = accept && (command == tvfs_pkg::CMD_WRITE) &&
                  (widx_ext < 32'(tvfs_pkg::GRID_CELLS));

  // corner k: bit 0 picks upper x, bit 1 upper y, bit 2 upper z
  assign rd_lin = ofs[0][rd_cnt[0]] + ofs[1][rd_cnt[1]] + ofs[2][rd_cnt[2]];

  always_comb begin
    if (state == S_IDLE) begin
      mem_addr = {array_select, widx_ext[LW-1:0]};
    end else begin
      mem_addr = {sel, rd_lin};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {value_z, value_y, value_x};
    end
    mem_rdata <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate unit
  // ---------------------------------------------------------------------------
  tvfs_pkg::mac_ctl_t mac_ctl;
  logic signed [tvfs_pkg::MUL_A_W-1:0] mac_a;
  logic signed [tvfs_pkg::MUL_B_W-1:0] mac_b;
  logic [tvfs_pkg::ACC_W-1:0] mac_init;
  logic [tvfs_pkg::ACC_W-1:0] acc;

  tvfs_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  // ---------------------------------------------------------------------------
  // Per-sample working registers
  // ---------------------------------------------------------------------------
  logic signed [tvfs_pkg::COORD_W-1:0] crd [3];
  logic [1:0] ax;
  logic [31:0] mag;
  logic d_neg;
  logic [AW-1:0] base0 [3];
  logic [AW-1:0] base1 [3];
  logic [FW-1:0] frac [3];
  logic [tvfs_pkg::WORD_W-1:0] corner [tvfs_pkg::NUM_CORNERS];
  logic signed [VW-1:0] tmp [4];
  logic [1:0] comp;
  logic [2:0] step;
  logic signed [VW-1:0] op_a;
  logic [tvfs_pkg::MUL_A_W-1:0] op_diff;
  logic [FW-1:0] op_f;

  // axis operand selection
  logic signed [tvfs_pkg::COORD_W-1:0] ax_coord;
  logic signed [tvfs_pkg::COORD_W-1:0] ax_origin;
  logic [tvfs_pkg::CFG_DATA_W-1:0] ax_inv;
  logic [AW-1:0] ax_dim_m1;
  logic [32:0] d_fwd;
  logic [32:0] d_rev;

  always_comb begin
    unique case (ax)
      2'd1: begin
        ax_coord = crd[1];
        ax_origin = origin[1];
        ax_inv = inv_spacing[1];
        ax_dim_m1 = DIM_Y_M1;
      end
      2'd2: begin
        ax_coord = crd[2];
        ax_origin = origin[2];
        ax_inv = inv_spacing[2];
        ax_dim_m1 = DIM_Z_M1;
      end
      default: begin
        ax_coord = crd[0];
        ax_origin = origin[0];
        ax_inv = inv_spacing[0];
        ax_dim_m1 = DIM_X_M1;
      end
    endcase
  end

  assign d_fwd = {ax_coord[31], ax_coord} - {ax_origin[31], ax_origin};
  assign d_rev = {ax_origin[31], ax_origin} - {ax_coord[31], ax_coord};

  // base corner and fraction from g = |d| * inv_spacing >> 16 (magnitude, Q.16)
  logic [GW-1:0] g;
  logic [GW-1:0] g_lim;
  logic [AW-1:0] f_base0;
  logic [AW-1:0] f_base1;
  logic [FW-1:0] f_frac;

  assign g = acc[tvfs_pkg::ACC_W-1:16];
  assign g_lim = GW'({ax_dim_m1, 16'h0000}) + FRAC_POS_G;

  always_comb begin
    if (d_neg) begin
      // below the origin: base stays at 0, fraction is negative
      f_base0 = '0;
      if (g > FRAC_POS_G) begin
        f_frac = FRAC_NEG;
      end else begin
        f_frac = FW'(0) - g[FW-1:0];
      end
    end else if (g[GW-1:16] <= 32'(ax_dim_m1)) begin
      f_base0 = g[16 +: AW];
      f_frac = FW'(g[15:0]);
    end else begin
      // beyond the far face: base clamps, fraction extrapolates
      f_base0 = ax_dim_m1;
      if (g > g_lim) begin
        f_frac = FRAC_POS;
      end else begin
        f_frac = g[FW-1:0] - FW'({ax_dim_m1, 16'h0000});
      end
    end
    f_base1 = (f_base0 == ax_dim_m1) ? ax_dim_m1 : f_base0 + 1'b1;
  end

  // lerp operand selection: x pairs, then y pairs, then z
  function automatic logic signed [VW-1:0] pick(input logic [tvfs_pkg::WORD_W-1:0] w,
                                                 input logic [1:0] c);
    logic [tvfs_pkg::VAL_W-1:0] s;
    unique case (c)
      2'd1:    s = w[tvfs_pkg::VAL_W +: tvfs_pkg::VAL_W];
      2'd2:    s = w[2*tvfs_pkg::VAL_W +: tvfs_pkg::VAL_W];
      default: s = w[0 +: tvfs_pkg::VAL_W];
    endcase
    return {{(VW - tvfs_pkg::VAL_W){s[tvfs_pkg::VAL_W-1]}}, s};
  endfunction

  logic signed [VW-1:0] lp_a;
  logic signed [VW-1:0] lp_b;
  logic [FW-1:0] lp_f;
  logic [1:0] lp_dst;
  logic signed [VW:0] lp_diff;

  always_comb begin
    unique case (step)
      3'd0, 3'd1, 3'd2, 3'd3: begin
        lp_a = pick(corner[{step[1:0], 1'b0}], comp);
        lp_b = pick(corner[{step[1:0], 1'b1}], comp);
        lp_f = frac[0];
        lp_dst = step[1:0];
      end
      3'd4: begin
        lp_a = tmp[0];
        lp_b = tmp[1];
        lp_f = frac[1];
        lp_dst = 2'd0;
      end
      3'd5: begin
        lp_a = tmp[2];
        lp_b = tmp[3];
        lp_f = frac[1];
        lp_dst = 2'd1;
      end
      default: begin  // final z lerp
        lp_a = tmp[0];
        lp_b = tmp[1];
        lp_f = frac[2];
        lp_dst = 2'd0;
      end
    endcase
  end

  assign lp_diff = {lp_b[VW-1], lp_b} - {lp_a[VW-1], lp_a};

  // MAC drive
  always_comb begin
    mac_ctl.op = tvfs_pkg::MAC_HOLD;
    mac_ctl.shift = tvfs_pkg::MAC_SH0;
    mac_a = {{(tvfs_pkg::MUL_A_W - 32){1'b0}}, mag};
    mac_b = {1'b0, ax_inv[15:0]};
    mac_init = '0;
    unique case (state)
      S_AX_M0: begin
        mac_ctl.op = tvfs_pkg::MAC_LOAD;
      end
      S_AX_M1: begin
        mac_ctl.op = tvfs_pkg::MAC_ADD;
        mac_ctl.shift = tvfs_pkg::MAC_SH16;
        mac_b = {1'b0, ax_inv[31:16]};
      end
      S_L0: begin
        // a*2^16 + half LSB, plus diff * low fraction bits
        mac_ctl.op = tvfs_pkg::MAC_LOAD;
        mac_a = op_diff;
        mac_b = tvfs_pkg::MUL_B_W'(op_f[tvfs_pkg::FRAC_LO_W-1:0]);
        mac_init = {{(tvfs_pkg::ACC_W - VW - 16){op_a[VW-1]}}, op_a, 16'h8000};
      end
      S_L1: begin
        mac_ctl.op = tvfs_pkg::MAC_ADD;
        mac_ctl.shift = tvfs_pkg::MAC_SH13;
        mac_a = op_diff;
        mac_b = {{(tvfs_pkg::MUL_B_W - FW + tvfs_pkg::FRAC_LO_W){op_f[FW-1]}},
                 op_f[FW-1:tvfs_pkg::FRAC_LO_W]};
      end
      default: ;
    endcase
  end

  // final saturation (floor of acc / 2^16)
  logic signed [47:0] r_full;
  logic [tvfs_pkg::OUT_W-1:0] r_sat;

  assign r_full = acc[tvfs_pkg::ACC_W-1:16];

  always_comb begin
    if (r_full > OUT_MAX) begin
      r_sat = OUT_MAX[tvfs_pkg::OUT_W-1:0];
    end else if (r_full < OUT_MIN) begin
      r_sat = OUT_MIN[tvfs_pkg::OUT_W-1:0];
    end else begin
      r_sat = r_full[tvfs_pkg::OUT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && command == tvfs_pkg::CMD_SAMPLE) begin
            sel <= array_select;
            crd[0] <= coord_x;
            crd[1] <= coord_y;
            crd[2] <= coord_z;
            ax <= 2'd0;
            state <= S_AX_D;
          end
        end
        S_AX_D: begin
          d_neg <= d_fwd[32];
          mag <= d_fwd[32] ? d_rev[31:0] : d_fwd[31:0];
          state <= S_AX_M0;
        end
        S_AX_M0: state <= S_AX_M1;
        S_AX_M1: state <= S_AX_F;
        S_AX_F: begin
          base0[ax] <= f_base0;
          base1[ax] <= f_base1;
          frac[ax] <= f_frac;
          if (ax == LAST_AXIS) begin
            state <= S_OFS;
          end else begin
            ax <= ax + 2'd1;
            state <= S_AX_D;
          end
        end
        S_OFS: begin
          ofs[0][0] <= LW'(32'(base0[0]));
          ofs[0][1] <= LW'(32'(base1[0]));
          ofs[1][0] <= LW'(32'(base0[1]) * 32'(tvfs_pkg::STRIDE_Y));
          ofs[1][1] <= LW'(32'(base1[1]) * 32'(tvfs_pkg::STRIDE_Y));
          ofs[2][0] <= LW'(32'(base0[2]) * 32'(tvfs_pkg::STRIDE_Z));
          ofs[2][1] <= LW'(32'(base1[2]) * 32'(tvfs_pkg::STRIDE_Z));
          rd_cnt <= '0;
          state <= S_RD;
        end
        S_RD: begin
          // read data is registered and belongs to the previous address
          if (rd_cnt != 4'd0) begin
            corner[3'(rd_cnt - 4'd1)] <= mem_rdata;
          end
          if (rd_cnt == LAST_READ) begin
            comp <= 2'd0;
            step <= 3'd0;
            state <= S_LP;
          end else begin
            rd_cnt <= rd_cnt + 4'd1;
          end
        end
        S_LP: begin
          op_a <= lp_a;
          op_diff <= lp_diff[tvfs_pkg::MUL_A_W-1:0];
          op_f <= lp_f;
          state <= S_L0;
        end
        S_L0: state <= S_L1;
        S_L1: state <= S_LW;
        S_LW: begin
          if (step == LAST_STEP) begin
            unique case (comp)
              2'd1:    sample_y <= r_sat;
              2'd2:    sample_z <= r_sat;
              default: sample_x <= r_sat;
            endcase
            step <= 3'd0;
            if (comp == LAST_COMP) begin
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              comp <= comp + 2'd1;
              state <= S_LP;
            end
          end else begin
            tmp[lp_dst] <= acc[VW+15:16];
            step <= step + 3'd1;
            state <= S_LP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/tvfs_mac.sv
// tvfs_mac: shared signed multiply-accumulate unit (38 x 17 bits into 64 bits).
// Depends on tvfs_pkg.
`default_nettype none

module tvfs_mac (
  input  wire logic                                clk,
  input  wire tvfs_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [tvfs_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [tvfs_pkg::MUL_B_W-1:0] b,
  input  wire logic        [tvfs_pkg::ACC_W-1:0]   init,
  output logic             [tvfs_pkg::ACC_W-1:0]   acc
);

  logic signed [tvfs_pkg::PROD_W-1:0] prod;
  logic [tvfs_pkg::ACC_W-1:0] prod_ext;
  logic [tvfs_pkg::ACC_W-1:0] addend;

  assign prod = a * b;
  assign prod_ext = {{(tvfs_pkg::ACC_W - tvfs_pkg::PROD_W){prod[tvfs_pkg::PROD_W-1]}}, prod};

  always_comb begin
    unique case (ctl.shift)
      tvfs_pkg::MAC_SH13: addend = prod_ext << 13;
      tvfs_pkg::MAC_SH16: addend = prod_ext << 16;
      default:            addend = prod_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      tvfs_pkg::MAC_LOAD: acc <= init + addend;
      tvfs_pkg::MAC_ADD:  acc <= acc + addend;
      default:            acc <= acc;
    endcase
  end

endmodule

`default_nettype wire
